// ===== rtl/weekly_alarm_scheduler_macros.svh =====
// Assertion macros shared by the weekly alarm scheduler RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef WEEKLY_ALARM_SCHEDULER_MACROS_SVH
`define WEEKLY_ALARM_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weekly alarm scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weekly alarm scheduler assertion failed");

`endif

// ===== rtl/was_pkg.sv =====
// Package for the weekly alarm scheduler: constants, opcodes, states and payload types.
// Used by the interfaces, the distance unit and the top level; no dependencies.
`timescale 1ns / 1ps

package was_pkg;

    localparam int NUM_ALARMS    = 8;
    localparam int IDX_W         = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int DAYS_PER_WEEK = 7;
    localparam int MIN_PER_DAY   = 1440;
    localparam int MIN_PER_HOUR  = 60;
    localparam int WEEK_WRAP     = (6 * 1440) + (23 * 60) + 59;
    localparam int DIST_W        = 15;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_STOP   = 2'd2,
        OP_RECOMP = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [6:0] days;
        logic [4:0] hour;
        logic [5:0] minute;
    } entry_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] alarm_index;
        logic       alarm_on;
        logic [6:0] alarm_days;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
    } req_t;

    typedef struct packed {
        logic       next_valid;
        logic [2:0] next_index;
        logic [2:0] next_weekday;
        logic       ringing;
        logic       ring_start;
        logic       ring_stop;
        logic       any_enabled;
    } rsp_t;

endpackage

// ===== rtl/was_ifs.sv =====
// Valid/ready channel interfaces for the request and response sides of the scheduler.
// Depends on was_pkg for the payload types.
`timescale 1ns / 1ps

interface was_req_if;
    logic          valid;
    logic          ready;
    was_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface was_rsp_if;
    logic          valid;
    logic          ready;
    was_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/was_dist_unit.sv =====
// Shared distance unit: minutes from a reference point to a weekday, hour and minute.
// Depends on was_pkg for constants and the entry type.
`timescale 1ns / 1ps

module was_dist_unit (
    input  logic [2:0]                  day,
    input  was_pkg::entry_t             entry,
    input  logic [was_pkg::DIST_W-1:0]  now,
    output logic [was_pkg::DIST_W-1:0]  key
);

    logic [was_pkg::DIST_W-1:0] at_w;
    logic [was_pkg::DIST_W-1:0] diff_w;

    assign at_w = was_pkg::DIST_W'(day) * was_pkg::DIST_W'(was_pkg::MIN_PER_DAY)
                + was_pkg::DIST_W'(entry.hour) * was_pkg::DIST_W'(was_pkg::MIN_PER_HOUR)
                + was_pkg::DIST_W'(entry.minute);

    assign diff_w = at_w - now;

    // A negative distance wraps by WEEK_WRAP (one week less one minute); a value still negative keeps its
    // two's complement pattern and therefore orders above every positive one.
    assign key = diff_w[was_pkg::DIST_W-1]
               ? diff_w + was_pkg::DIST_W'(was_pkg::WEEK_WRAP)
               : diff_w;

endmodule

// ===== rtl/weekly_alarm_scheduler.sv =====
// Top level of the weekly alarm scheduler: request decode, alarm table, search sequencer.
// Depends on was_pkg, was_ifs, was_dist_unit and the assertion macro header.
//
// Usage: each request on the req channel carries an operation (time tick, write
// alarm entry, stop ringing, recompute) with the current weekday, hour, minute and
// second, plus the alarm entry fields for writes. Every request yields exactly one
// response on the rsp channel with the chosen next alarm and the ringing flags.
// A tick that needs no search goes from acceptance straight to the done state. A
// write, stop, recompute, or a tick that ends ringing runs a search over every
// alarm and weekday, one candidate per cycle through the shared distance unit,
// after a setup state that forms the current time, and then enters the done state,
// where the response register is loaded. The block takes one request at a time and
// raises req.ready again the cycle after the response register is loaded, even if
// that response is still waiting. If the receiver stalls, the response is held and
// the next result waits in the sequencer. Reset disables every alarm, clears the
// choice and ringing, and drops any pending response.
`timescale 1ns / 1ps
`include "weekly_alarm_scheduler_macros.svh"

module weekly_alarm_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    was_req_if.sink   req,
    was_rsp_if.source rsp
);

    was_pkg::state_t                   state_reg;
    was_pkg::state_t                   state_next;

    logic [was_pkg::NUM_ALARMS-1:0]    on_reg;
    was_pkg::entry_t                   tbl_reg [was_pkg::NUM_ALARMS];

    logic [2:0]                        cur_day_reg;
    logic [4:0]                        cur_hour_reg;
    logic [5:0]                        cur_min_reg;
    logic [was_pkg::DIST_W-1:0]        now_reg;

    logic                              chosen_valid_reg;
    logic [2:0]                        chosen_index_reg;
    logic [2:0]                        chosen_day_reg;
    was_pkg::entry_t                   chosen_entry_reg;
    logic                              ring_reg;
    logic                              start_reg;
    logic                              stop_reg;

    logic [was_pkg::IDX_W-1:0]         scan_idx_reg;
    logic [2:0]                        scan_day_reg;
    logic                              found_reg;
    logic [was_pkg::DIST_W-1:0]        best_reg;
    logic [was_pkg::IDX_W-1:0]         best_idx_reg;
    logic [2:0]                        best_day_reg;
    was_pkg::entry_t                   best_entry_reg;

    logic                              out_valid_reg;
    was_pkg::rsp_t                     out_data_reg;

    logic                              accept;
    logic                              hit;
    logic [7:0]                        chosen_days_ext;
    logic [7:0]                        scan_days_ext;
    was_pkg::entry_t                   scan_entry;
    logic                              cand;
    logic                              take;
    logic                              found_w;
    logic [was_pkg::IDX_W-1:0]         best_idx_w;
    logic [2:0]                        best_day_w;
    was_pkg::entry_t                   best_entry_w;
    logic                              scan_last;
    logic                              out_load;

    logic [2:0]                        unit_day;
    was_pkg::entry_t                   unit_entry;
    logic [was_pkg::DIST_W-1:0]        unit_now;
    logic [was_pkg::DIST_W-1:0]        unit_key;

    assign req.ready = (state_reg == was_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign chosen_days_ext = {1'b0, chosen_entry_reg.days};
    assign hit = chosen_valid_reg && chosen_days_ext[req.data.day]
              && (chosen_entry_reg.hour == req.data.hour)
              && (chosen_entry_reg.minute == req.data.minute);

    assign scan_entry    = tbl_reg[scan_idx_reg];
    assign scan_days_ext = {1'b0, scan_entry.days};
    assign cand          = on_reg[scan_idx_reg] && scan_days_ext[scan_day_reg];

    // The setup state runs the same unit on the current time to form "now".
    always_comb
    begin
        if (state_reg == was_pkg::ST_SETUP)
        begin
            unit_day   = cur_day_reg;
            unit_entry = '{days: 7'd0, hour: cur_hour_reg, minute: cur_min_reg};
            unit_now   = '0;
        end
        else
        begin
            unit_day   = scan_day_reg;
            unit_entry = scan_entry;
            unit_now   = now_reg;
        end
    end

    was_dist_unit u_dist (
        .day   (unit_day),
        .entry (unit_entry),
        .now   (unit_now),
        .key   (unit_key)
    );

    assign take         = cand && (!found_reg || (unit_key < best_reg));
    assign found_w      = found_reg || take;
    assign best_idx_w   = take ? scan_idx_reg : best_idx_reg;
    assign best_day_w   = take ? scan_day_reg : best_day_reg;
    assign best_entry_w = take ? scan_entry : best_entry_reg;
    assign scan_last    = (scan_idx_reg == '0) && (scan_day_reg == '0);
    assign out_load     = (state_reg == was_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            was_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.data.operation == was_pkg::OP_TICK)
                        && (hit || !(ring_reg || (hit && (req.data.second == 6'd0)))))
                    begin
                        state_next = was_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = was_pkg::ST_SETUP;
                    end
                end
            end
            was_pkg::ST_SETUP:
            begin
                state_next = was_pkg::ST_SCAN;
            end
            was_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = was_pkg::ST_DONE;
                end
            end
            was_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = was_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = was_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= was_pkg::ST_IDLE;
            on_reg           <= '0;
            chosen_valid_reg <= 1'b0;
            chosen_index_reg <= 3'd0;
            chosen_day_reg   <= 3'd0;
            ring_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                case (req.data.operation)
                    was_pkg::OP_TICK:
                    begin
                        if (ring_reg || (hit && (req.data.second == 6'd0)))
                        begin
                            ring_reg <= hit;
                        end
                    end
                    was_pkg::OP_WRITE:
                    begin
                        if (32'(req.data.alarm_index) < was_pkg::NUM_ALARMS)
                        begin
                            on_reg[was_pkg::IDX_W'(req.data.alarm_index)] <= req.data.alarm_on;
                        end
                    end
                    was_pkg::OP_STOP:
                    begin
                        ring_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if ((state_reg == was_pkg::ST_SCAN) && scan_last)
            begin
                chosen_valid_reg <= found_w;
                if (found_w)
                begin
                    chosen_index_reg <= 3'(best_idx_w);
                    chosen_day_reg   <= best_day_w;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_day_reg  <= req.data.day;
            cur_hour_reg <= req.data.hour;
            cur_min_reg  <= req.data.minute;
            start_reg    <= 1'b0;
            stop_reg     <= 1'b0;
            case (req.data.operation)
                was_pkg::OP_TICK:
                begin
                    if (ring_reg || (hit && (req.data.second == 6'd0)))
                    begin
                        start_reg <= hit && !ring_reg;
                        stop_reg  <= !hit;
                    end
                end
                was_pkg::OP_WRITE:
                begin
                    if (32'(req.data.alarm_index) < was_pkg::NUM_ALARMS)
                    begin
                        tbl_reg[was_pkg::IDX_W'(req.data.alarm_index)] <= '{
                            days:   req.data.alarm_days,
                            hour:   req.data.alarm_hour,
                            minute: req.data.alarm_minute
                        };
                    end
                end
                was_pkg::OP_STOP:
                begin
                    stop_reg <= ring_reg;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            was_pkg::ST_SETUP:
            begin
                now_reg      <= unit_key + was_pkg::DIST_W'(1);
                scan_idx_reg <= was_pkg::IDX_W'(was_pkg::NUM_ALARMS - 1);
                scan_day_reg <= 3'(was_pkg::DAYS_PER_WEEK - 1);
                found_reg    <= 1'b0;
            end
            was_pkg::ST_SCAN:
            begin
                found_reg      <= found_w;
                best_idx_reg   <= best_idx_w;
                best_day_reg   <= best_day_w;
                best_entry_reg <= best_entry_w;
                if (take)
                begin
                    best_reg <= unit_key;
                end
                if (scan_day_reg == 3'd0)
                begin
                    scan_idx_reg <= scan_idx_reg - was_pkg::IDX_W'(1);
                    scan_day_reg <= 3'(was_pkg::DAYS_PER_WEEK - 1);
                end
                else
                begin
                    scan_day_reg <= scan_day_reg - 3'd1;
                end
                if (scan_last && found_w)
                begin
                    chosen_entry_reg <= best_entry_w;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_data_reg.next_valid   <= chosen_valid_reg;
            out_data_reg.next_index   <= chosen_valid_reg ? chosen_index_reg : 3'd0;
            out_data_reg.next_weekday <= chosen_valid_reg ? chosen_day_reg : 3'd0;
            out_data_reg.ringing      <= ring_reg;
            out_data_reg.ring_start   <= start_reg;
            out_data_reg.ring_stop    <= stop_reg;
            out_data_reg.any_enabled  <= |on_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    `WAS_ASSERT_IMPL(a_start_stop_excl, clk, rst_n, out_valid_reg, !(out_data_reg.ring_start && out_data_reg.ring_stop))
    `WAS_ASSERT_IMPL(a_start_rings, clk, rst_n, out_valid_reg && out_data_reg.ring_start, out_data_reg.ringing)
    `WAS_ASSERT_IMPL(a_idle_choice, clk, rst_n, out_valid_reg && !out_data_reg.next_valid, (out_data_reg.next_index == 3'd0) && (out_data_reg.next_weekday == 3'd0))
    `WAS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    `WAS_ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_reg == was_pkg::ST_SCAN) && scan_last, state_reg == was_pkg::ST_DONE)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for weekly_alarm_scheduler: directed alarm and ringing cases,
// then random request episodes checked against an in-bench schedule predictor.
// Depends on was_pkg, the was_ifs channel interfaces and the weekly_alarm_scheduler RTL.
`timescale 1ns / 1ps

module testbench;
    import was_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int REQUEST_COUNT = 1150;
    localparam int IDLE_PERCENT  = 28;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_CYCLES   = 600;

    class schedule_scoreboard;
        bit [NUM_ALARMS-1:0] alarm_en;
        entry_t              alarms [NUM_ALARMS];
        bit                  chosen_valid;
        logic [2:0]          chosen_index;
        logic [2:0]          chosen_day;
        bit                  ring_flag;
        rsp_t                pending_rsp [$];
        int                  n_errors;
        int                  n_checked;
        int                  n_writes;
        int                  n_ticks;
        int                  n_starts;
        int                  n_stops;

        function new();
            alarm_en = '0;
            foreach (alarms[i])
                alarms[i] = '0;
            chosen_valid = 0;
            chosen_index = '0;
            chosen_day   = '0;
            ring_flag    = 0;
        endfunction

        function void find_next_alarm(int day, int hour, int minute);
            int          now_min;
            int          at_min;
            int          delta;
            int unsigned udist;
            int unsigned best;
            bit          found;
            now_min = day * MIN_PER_DAY + hour * MIN_PER_HOUR + minute + 1;
            best    = '1;
            found   = 0;
            for (int i = NUM_ALARMS - 1; i >= 0; i--)
            begin
                if (!alarm_en[i])
                    continue;
                for (int d = DAYS_PER_WEEK - 1; d >= 0; d--)
                begin
                    if (!alarms[i].days[d])
                        continue;
                    at_min = d * MIN_PER_DAY + int'(alarms[i].hour) * MIN_PER_HOUR
                             + int'(alarms[i].minute);
                    delta = at_min - now_min;
                    if (delta < 0)
                        delta += WEEK_WRAP;
                    udist = delta;
                    if (udist < best)
                    begin
                        best         = udist;
                        found        = 1;
                        chosen_index = 3'(i);
                        chosen_day   = 3'(d);
                    end
                end
            end
            chosen_valid = found;
        endfunction

        function bit alarm_hits(int day, int hour, int minute);
            entry_t e;
            if (!chosen_valid || day >= DAYS_PER_WEEK)
                return 0;
            e = alarms[chosen_index];
            if (!e.days[day])
                return 0;
            return (int'(e.hour) == hour) && (int'(e.minute) == minute);
        endfunction

        function void note_request(req_t r);
            rsp_t want;
            bit   was_ringing;
            bit   hit;
            bit   start;
            bit   stop;
            start = 0;
            stop  = 0;
            case (op_t'(r.operation))
                OP_TICK:
                begin
                    n_ticks++;
                    was_ringing = ring_flag;
                    hit = alarm_hits(r.day, r.hour, r.minute);
                    if (hit && r.second == 0)
                        ring_flag = 1;
                    if (ring_flag)
                    begin
                        if (hit)
                            start = !was_ringing;
                        else
                        begin
                            find_next_alarm(r.day, r.hour, r.minute);
                            ring_flag = 0;
                            stop = 1;
                        end
                    end
                end
                OP_WRITE:
                begin
                    n_writes++;
                    if (r.alarm_index < NUM_ALARMS)
                    begin
                        alarm_en[r.alarm_index] = r.alarm_on;
                        alarms[r.alarm_index] = {r.alarm_days, r.alarm_hour, r.alarm_minute};
                    end
                    find_next_alarm(r.day, r.hour, r.minute);
                end
                OP_STOP:
                begin
                    find_next_alarm(r.day, r.hour, r.minute);
                    stop = ring_flag;
                    ring_flag = 0;
                end
                OP_RECOMP:
                    find_next_alarm(r.day, r.hour, r.minute);
            endcase
            n_starts += start;
            n_stops  += stop;
            want.next_valid   = chosen_valid;
            want.next_index   = chosen_valid ? chosen_index : 3'd0;
            want.next_weekday = chosen_valid ? chosen_day : 3'd0;
            want.ringing      = ring_flag;
            want.ring_start   = start;
            want.ring_stop    = stop;
            want.any_enabled  = |alarm_en;
            pending_rsp.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding: %p", got);
                n_errors++;
                return;
            end
            want = pending_rsp.pop_front();
            n_checked++;
            compare_field("next_valid", want.next_valid, got.next_valid);
            compare_field("next_index", want.next_index, got.next_index);
            compare_field("next_weekday", want.next_weekday, got.next_weekday);
            compare_field("ringing", want.ringing, got.ringing);
            compare_field("ring_start", want.ring_start, got.ring_start);
            compare_field("ring_stop", want.ring_stop, got.ring_stop);
            compare_field("any_enabled", want.any_enabled, got.any_enabled);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   n_sent;
    bit   quiet_window;

    schedule_scoreboard sb = new();

    was_req_if req_ch();
    was_rsp_if rsp_ch();

    weekly_alarm_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
    end

    initial
    begin : response_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        rsp_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 0;
            end
            else if (!held && sb.n_checked >= 300)
            begin
                held = 1;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 0;
            end
            else if (quiet_window)
                rsp_ch.ready <= 1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("weekly_alarm_scheduler verification failed");
        $finish;
    end

    function automatic req_t make_req(op_t op, int day, int hour, int minute, int second,
                                      int idx = 0, int on = 0, int days = 0,
                                      int ahour = 0, int amin = 0);
        req_t r;
        r.operation    = op;
        r.day          = 3'(day);
        r.hour         = 5'(hour);
        r.minute       = 6'(minute);
        r.second       = 6'(second);
        r.alarm_index  = 3'(idx);
        r.alarm_on     = 1'(on);
        r.alarm_days   = 7'(days);
        r.alarm_hour   = 5'(ahour);
        r.alarm_minute = 6'(amin);
        return r;
    endfunction

    function automatic req_t random_request(op_t op);
        req_t r;
        r = '0;
        r.operation = op;
        if ($urandom_range(19) == 0)
        begin
            r.day    = 3'($urandom);
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
        end
        else
        begin
            r.day    = 3'($urandom_range(6));
            r.hour   = 5'($urandom_range(23));
            r.minute = 6'($urandom_range(59));
        end
        r.second      = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom);
        r.alarm_index = 3'($urandom);
        r.alarm_on    = ($urandom_range(99) < 70);
        r.alarm_days  = 7'($urandom);
        if ($urandom_range(9) == 0)
        begin
            r.alarm_hour   = 5'($urandom);
            r.alarm_minute = 6'($urandom);
        end
        else
        begin
            r.alarm_hour   = 5'($urandom_range(23));
            r.alarm_minute = 6'($urandom_range(59));
        end
        return r;
    endfunction

    task automatic send_request(req_t r);
        while (!quiet_window && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 0;
            @(negedge clk);
        end
        req_ch.valid <= 1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic play_directed_alarms();
        send_request(make_req(OP_RECOMP, 0, 0, 0, 0));
        send_request(make_req(OP_TICK, 0, 0, 0, 0));
        send_request(make_req(OP_WRITE, 6, 23, 59, 59, 7, 1, 7'h7f, 23, 59));
        send_request(make_req(OP_WRITE, 7, 31, 63, 63, 0, 1, 7'h01, 0, 0));
        send_request(make_req(OP_WRITE, 3, 12, 0, 30, 3, 1, 7'h40, 31, 63));
        send_request(make_req(OP_WRITE, 2, 8, 29, 0, 5, 1, 7'h04, 8, 30));
        send_request(make_req(OP_WRITE, 2, 8, 29, 0, 2, 1, 7'h04, 8, 30));
        send_request(make_req(OP_TICK, 2, 8, 30, 5));
        send_request(make_req(OP_TICK, 2, 8, 30, 0));
        send_request(make_req(OP_TICK, 2, 8, 30, 1));
        send_request(make_req(OP_WRITE, 2, 8, 30, 2, 1, 1, 7'h02, 1, 1));
        send_request(make_req(OP_TICK, 2, 8, 30, 3));
        send_request(make_req(OP_RECOMP, 2, 8, 29, 0));
        send_request(make_req(OP_TICK, 2, 8, 30, 0));
        send_request(make_req(OP_STOP, 2, 8, 30, 10));
        send_request(make_req(OP_STOP, 2, 8, 30, 11));
        send_request(make_req(OP_RECOMP, 2, 8, 29, 0));
        send_request(make_req(OP_TICK, 2, 8, 30, 0));
        send_request(make_req(OP_TICK, 2, 8, 31, 0));
        send_request(make_req(OP_TICK, 7, 8, 30, 0));
        send_request(make_req(OP_WRITE, 2, 8, 31, 1, 5, 0, 7'h00, 0, 0));
        send_request(make_req(OP_WRITE, 2, 8, 31, 2, 6, 1, 7'h00, 5, 5));
    endtask

    task automatic run_random_episode();
        req_t   r;
        entry_t e;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            if (!sb.chosen_valid)
            begin
                r = random_request(OP_WRITE);
                r.alarm_on = 1;
                r.alarm_days[3'($urandom_range(6))] = 1'b1;
                send_request(r);
            end
            else
            begin
                e = sb.alarms[sb.chosen_index];
                r = random_request(OP_TICK);
                r.day    = sb.chosen_day;
                r.hour   = e.hour;
                r.minute = e.minute;
                r.second = ($urandom_range(3) == 0) ? 6'($urandom) : 6'd0;
                send_request(r);
                repeat ($urandom_range(3))
                begin
                    r.second = 6'($urandom_range(1, 63));
                    send_request(r);
                end
                case ($urandom_range(3))
                    0: r.operation = OP_STOP;
                    1: r.minute = r.minute + 6'd1;
                    2: r = random_request(OP_WRITE);
                    default: r = random_request(OP_RECOMP);
                endcase
                send_request(r);
            end
        end
        else if (pick < 70)
            send_request(random_request(OP_WRITE));
        else if (pick < 85)
            send_request(random_request(($urandom_range(1) == 0) ? OP_STOP : OP_RECOMP));
        else
        begin
            r = random_request(op_t'($urandom_range(3)));
            r.day    = 3'($urandom);
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
            r.second = 6'($urandom);
            send_request(r);
        end
    endtask

    initial
    begin : stimulus
        rst_n        = 0;
        quiet_window = 0;
        n_sent       = 0;
        req_ch.valid = 0;
        req_ch.data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        play_directed_alarms();
        while (n_sent < REQUEST_COUNT)
        begin
            quiet_window = (n_sent >= 500 && n_sent < 700);
            run_random_episode();
        end
        quiet_window = 0;
        req_ch.valid <= 0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d responses to %0d requests (%0d writes, %0d ticks).",
                 sb.n_checked, n_sent, sb.n_writes, sb.n_ticks);
        $display("Alarms began ringing %0d times and were stopped %0d times.",
                 sb.n_starts, sb.n_stops);
        if (sb.n_errors == 0)
            $display("weekly_alarm_scheduler verification clean");
        else
            $display("weekly_alarm_scheduler verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/was_pkg.sv
rtl/was_ifs.sv
rtl/was_dist_unit.sv
rtl/weekly_alarm_scheduler.sv
dv/testbench.sv
